[src/acls_pkg.sv]
// Package for the append-only counter log: word types, command codes,
// datapath operation codes and controller status. No dependencies.
package acls_pkg;

    localparam int LOG_SLOTS_DEF = 256;
    localparam int MAX_KEYS_DEF  = 64;

    localparam logic [1:0] CMD_GET   = 2'd0;
    localparam logic [1:0] CMD_INC   = 2'd1;
    localparam logic [1:0] CMD_RAISE = 2'd2;
    // Unused code; behaves as a get
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key_hash;
        logic [31:0] value;
    } acls_req_t;

    typedef struct packed {
        logic [31:0] count_value;
        logic        record_written;
        logic        compacted;
        logic [8:0]  slots_used;
    } acls_rsp_t;

    // One log slot or one key table entry
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] cnt;
    } acls_rec_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_C_INIT,
        OP_C_RD_LOG,
        OP_C_J0,
        OP_C_TAB,
        OP_C_CMP,
        OP_CP_INIT,
        OP_CP_RD,
        OP_CP_WR,
        OP_CP_END,
        OP_APPEND
    } acls_op_t;

    typedef struct packed {
        logic scan_done;
        logic rescan;
        logic want;
        logic full;
        logic c_more;
        logic j_at_kept;
        logic tab_match;
    } acls_stat_t;

endpackage

[src/append_log_counter_store_top.sv]
// Top level of the append-only counter log: controller and datapath.
// Depends on acls_pkg, acls_ctrl, acls_dp.
//
//  channel   | handshake        | payload
//  ----------+------------------+----------------------------------------
//  request   | start / busy     | req : command, key_hash, value
//  result    | done (one cycle) | rsp : count_value, record_written,
//            |                  |       compacted, slots_used
//
// A request scans the log, one log slot read per cycle from the log RAM
// port, and may then append a record. A compaction adds a walk of the log
// with a key table search per slot, a copy-back of each key and a rescan
// of the compacted log.
// Reset empties the log at once. Results cannot be stalled: done is high
// for one cycle and busy stays high until then.
module append_log_counter_store_top
    import acls_pkg::*;
#(
    parameter int LOG_SLOTS = LOG_SLOTS_DEF,
    parameter int MAX_KEYS  = MAX_KEYS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  acls_req_t req,
    output logic      done,
    output acls_rsp_t rsp
);

    acls_op_t   op;
    acls_stat_t stat;

    acls_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .op    (op),
        .stat  (stat)
    );

    acls_dp #(
        .LOG_SLOTS (LOG_SLOTS),
        .MAX_KEYS  (MAX_KEYS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .op    (op),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

[src/acls_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module acls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; hold read data while idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/acls_ctrl.sv]
// Controller for the counter log: sequences scan, compaction, copy-back,
// append and result. Depends on acls_pkg.
module acls_ctrl
    import acls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    output acls_op_t   op,
    input  acls_stat_t stat
);

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_SCAN    = 13'b0000000000010,
        ST_DECIDE  = 13'b0000000000100,
        ST_C_INIT  = 13'b0000000001000,
        ST_C_LOOP  = 13'b0000000010000,
        ST_C_WAIT  = 13'b0000000100000,
        ST_C_TAB   = 13'b0000001000000,
        ST_C_CMP   = 13'b0000010000000,
        ST_CP_RD   = 13'b0000100000000,
        ST_CP_WR   = 13'b0001000000000,
        ST_POST    = 13'b0010000000000,
        ST_APPEND  = 13'b0100000000000,
        ST_OUT     = 13'b1000000000000
    } acls_state_t;

    acls_state_t state_reg, state_next;
    logic        rs_reg, rs_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rs_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rs_reg    <= rs_next;
        end
    end

    // Advance the sequence; rs_reg marks a pending rescan start
    always_comb
    begin
        state_next = state_reg;
        rs_next    = 1'b0;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rs_reg)
                begin
                    op = OP_SCAN_INIT;
                end
                else
                begin
                    op = OP_SCAN;
                    if (stat.scan_done)
                    begin
                        state_next = stat.rescan ? ST_OUT : ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (!stat.want)
                begin
                    state_next = ST_OUT;
                end
                else if (stat.full)
                begin
                    state_next = ST_C_INIT;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_C_INIT:
            begin
                op         = OP_C_INIT;
                state_next = ST_C_LOOP;
            end
            ST_C_LOOP:
            begin
                if (stat.c_more)
                begin
                    op         = OP_C_RD_LOG;
                    state_next = ST_C_WAIT;
                end
                else
                begin
                    op         = OP_CP_INIT;
                    state_next = ST_CP_RD;
                end
            end
            ST_C_WAIT:
            begin
                op         = OP_C_J0;
                state_next = ST_C_TAB;
            end
            ST_C_TAB:
            begin
                op         = OP_C_TAB;
                state_next = stat.j_at_kept ? ST_C_LOOP : ST_C_CMP;
            end
            ST_C_CMP:
            begin
                op         = OP_C_CMP;
                state_next = stat.tab_match ? ST_C_LOOP : ST_C_TAB;
            end
            ST_CP_RD:
            begin
                if (stat.j_at_kept)
                begin
                    op         = OP_CP_END;
                    state_next = ST_POST;
                end
                else
                begin
                    op         = OP_CP_RD;
                    state_next = ST_CP_WR;
                end
            end
            ST_CP_WR:
            begin
                op         = OP_CP_WR;
                state_next = ST_CP_RD;
            end
            ST_POST:
            begin
                if (stat.full)
                begin
                    rs_next    = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                op = OP_APPEND;
                if (stat.rescan)
                begin
                    rs_next    = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_OUT);

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result word not followed by idle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");
    a_rescan_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rs_reg |-> state_reg == ST_SCAN)
        else $error("rescan start outside scan");
`endif

endmodule

[src/acls_dp.sv]
// Datapath for the counter log: request, scan and compaction registers,
// log RAM and key table RAM. Depends on acls_pkg and acls_ram.
module acls_dp
    import acls_pkg::*;
#(
    parameter int LOG_SLOTS = LOG_SLOTS_DEF,
    parameter int MAX_KEYS  = MAX_KEYS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  acls_req_t  req,
    input  acls_op_t   op,
    output acls_stat_t stat,
    output acls_rsp_t  rsp
);

    localparam int SA_W = $clog2(LOG_SLOTS);
    localparam int FC_W = $clog2(LOG_SLOTS + 1);
    localparam int KA_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int KC_W = $clog2(MAX_KEYS + 1);
    localparam int RW   = $bits(acls_rec_t);

    acls_req_t       req_reg;
    logic [FC_W-1:0] fill_reg, fill_next;
    logic [FC_W-1:0] idx_reg, idx_next;
    logic [KC_W-1:0] j_reg, j_next;
    logic [KC_W-1:0] kept_reg, kept_next;
    logic [31:0]     best_reg, best_next;
    logic            vld_reg, vld_next;
    logic            written_reg, written_next;
    logic            comp_reg, comp_next;

    logic            log_we, log_re, tab_we, tab_re;
    logic [SA_W-1:0] log_wa, log_ra;
    acls_rec_t       log_wd, log_rd, tab_wd, tab_rd;
    logic            idx_lt_fill;
    logic [31:0]     new_cnt;

    // Status towards the controller
    assign idx_lt_fill    = (idx_reg < fill_reg);
    assign new_cnt        = (req_reg.command == CMD_INC) ? best_reg + 32'd1 : req_reg.value;
    assign stat.scan_done = !idx_lt_fill && !vld_reg;
    assign stat.rescan    = comp_reg;
    assign stat.want      = (req_reg.command == CMD_INC) ||
                            ((req_reg.command == CMD_RAISE) && (req_reg.value > best_reg));
    assign stat.full      = (fill_reg == FC_W'(LOG_SLOTS));
    assign stat.c_more    = idx_lt_fill && (kept_reg < KC_W'(MAX_KEYS));
    assign stat.j_at_kept = (j_reg == kept_reg);
    assign stat.tab_match = (tab_rd.key == log_rd.key);

    // Result word
    assign rsp.count_value    = best_reg;
    assign rsp.record_written = written_reg;
    assign rsp.compacted      = comp_reg;
    assign rsp.slots_used     = 9'(fill_reg);

    // Latch the request word
    always_ff @(posedge clk)
    begin
        if (op == OP_LOAD)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            idx_reg     <= '0;
            j_reg       <= '0;
            kept_reg    <= '0;
            best_reg    <= '0;
            vld_reg     <= 1'b0;
            written_reg <= 1'b0;
            comp_reg    <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            j_reg       <= j_next;
            kept_reg    <= kept_next;
            best_reg    <= best_next;
            vld_reg     <= vld_next;
            written_reg <= written_next;
            comp_reg    <= comp_next;
        end
    end

    // Perform the operation the controller asks for
    always_comb
    begin
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        j_next       = j_reg;
        kept_next    = kept_reg;
        best_next    = best_reg;
        vld_next     = 1'b0;
        written_next = written_reg;
        comp_next    = comp_reg;
        log_we       = 1'b0;
        log_wa       = SA_W'(j_reg);
        log_wd       = tab_rd;
        log_re       = 1'b0;
        log_ra       = idx_reg[SA_W-1:0];
        tab_we       = 1'b0;
        tab_wd       = log_rd;
        tab_re       = 1'b0;

        // Fold a returning scan word into the running maximum
        if (vld_reg && (log_rd.key == req_reg.key_hash) && (log_rd.cnt > best_reg))
        begin
            best_next = log_rd.cnt;
        end

        case (op)
            OP_LOAD:
            begin
                best_next    = '0;
                idx_next     = '0;
                written_next = 1'b0;
                comp_next    = 1'b0;
            end
            OP_SCAN_INIT:
            begin
                best_next = '0;
                idx_next  = '0;
            end
            OP_SCAN:
            begin
                if (idx_lt_fill)
                begin
                    log_re   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    vld_next = 1'b1;
                end
            end
            OP_C_INIT:
            begin
                idx_next  = '0;
                kept_next = '0;
                comp_next = 1'b1;
            end
            OP_C_RD_LOG:
            begin
                log_re = 1'b1;
            end
            OP_C_J0:
            begin
                j_next = '0;
            end
            OP_C_TAB:
            begin
                if (j_reg == kept_reg)
                begin
                    // New key: add it to the table
                    tab_we    = 1'b1;
                    kept_next = kept_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    tab_re = 1'b1;
                end
            end
            OP_C_CMP:
            begin
                if (tab_rd.key == log_rd.key)
                begin
                    tab_we   = (log_rd.cnt > tab_rd.cnt);
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            OP_CP_INIT:
            begin
                j_next = '0;
            end
            OP_CP_RD:
            begin
                tab_re = 1'b1;
            end
            OP_CP_WR:
            begin
                log_we = 1'b1;
                j_next = j_reg + 1'b1;
            end
            OP_CP_END:
            begin
                fill_next = FC_W'(kept_reg);
            end
            OP_APPEND:
            begin
                log_we       = 1'b1;
                log_wa       = fill_reg[SA_W-1:0];
                log_wd.key   = req_reg.key_hash;
                log_wd.cnt   = new_cnt;
                fill_next    = fill_reg + 1'b1;
                written_next = 1'b1;
                if (new_cnt > best_reg)
                begin
                    best_next = new_cnt;
                end
            end
            default:
            begin
            end
        endcase
    end

    acls_ram #(
        .WIDTH (RW),
        .DEPTH (LOG_SLOTS),
        .AW    (SA_W)
    ) u_log_ram (
        .clk     (clk),
        .wr_en   (log_we),
        .wr_addr (log_wa),
        .wr_data (log_wd),
        .rd_en   (log_re),
        .rd_addr (log_ra),
        .rd_data (log_rd)
    );

    acls_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_KEYS),
        .AW    (KA_W)
    ) u_tab_ram (
        .clk     (clk),
        .wr_en   (tab_we),
        .wr_addr (j_reg[KA_W-1:0]),
        .wr_data (tab_wd),
        .rd_en   (tab_re),
        .rd_addr (j_reg[KA_W-1:0]),
        .rd_data (tab_rd)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FC_W'(LOG_SLOTS))
        else $error("fill level beyond log size");
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= KC_W'(MAX_KEYS))
        else $error("key table overrun");
    a_append_flag: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_APPEND |=> written_reg && fill_reg == $past(fill_reg) + 1'b1)
        else $error("append did not advance fill level");
`endif

endmodule
